/* rtl/assert_macros.svh */
// Assertion macros used by the checker file coapp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low asynchronous reset that disables it.
`define CHK_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("coap parser check failed");

// The same on the usual clock and reset port names.
`define CHK_ASSERT_DFLT(name, prop) \
  `CHK_ASSERT(name, clk_i, rst_ni, prop)

`endif

/* rtl/coapp_pkg.sv */
`timescale 1ns / 1ps
package coapp_pkg;

  localparam int unsigned MaxMessageBytes = 1024;
  localparam int unsigned PayloadCapInt =
      ((MaxMessageBytes - 5) < 1023) ? (MaxMessageBytes - 5) : 1023;
  localparam logic [9:0] PayloadCap = 10'(PayloadCapInt);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TOKEN   = 3'd1,
    PH_OPTS    = 3'd2,
    PH_DEXT    = 3'd3,
    PH_LEXT    = 3'd4,
    PH_VALUE   = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_IGNORE  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_TOKEN   = 3'd1,
    KIND_OPTHEAD = 3'd2,
    KIND_OPTEXT  = 3'd3,
    KIND_OPTVAL  = 3'd4,
    KIND_MARKER  = 3'd5,
    KIND_PAYLOAD = 3'd6,
    KIND_IGNORED = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_VERSION  = 3'd1,
    ST_NIBBLE15 = 3'd2,
    ST_EARLY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    logic       truncated_frame;
  } in_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data_byte;
    logic        option_start;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [1:0]  message_type;
    logic [7:0]  message_code;
    logic [15:0] message_id;
    logic [3:0]  token_length;
    logic [9:0]  payload_length;
    logic        done_res;
    logic [2:0]  status;
  } out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trunc;
    logic       ver_ok;
    logic       marker;
    logic       nib15;
    logic [3:0] hi;
    logic [3:0] lo;
  } dec_t;

endpackage

/* rtl/coapp_front.sv */
`timescale 1ns / 1ps
module coapp_front import coapp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  in_t        in_data_i,
  output dec_t       dec_o
);

  logic [1:0] version_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= 2'd1;
    end else if (cfg_we_i) begin
      version_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    dec_o.data   = in_data_i.rx_byte;
    dec_o.last   = in_data_i.last_byte;
    dec_o.trunc  = in_data_i.truncated_frame;
    dec_o.ver_ok = (in_data_i.rx_byte[7:6] == version_q);
    dec_o.marker = (in_data_i.rx_byte == 8'hff);
    dec_o.hi     = in_data_i.rx_byte[7:4];
    dec_o.lo     = in_data_i.rx_byte[3:0];
    dec_o.nib15  = (in_data_i.rx_byte[7:4] == 4'hf) || (in_data_i.rx_byte[3:0] == 4'hf);
  end

endmodule

/* rtl/coapp_queue.sv */
`timescale 1ns / 1ps
module coapp_queue import coapp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  dec_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output dec_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  dec_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/coapp_back.sv */
`timescale 1ns / 1ps
module coapp_back import coapp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  dec_t dec_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  pos;
    logic [16:0] rem;
    logic [15:0] run;
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [15:0] acc;
    logic [16:0] pend;
    logic [9:0]  pc;
    logic [1:0]  mtype;
    logic [3:0]  tkl;
    logic [7:0]  code;
    logic [15:0] id;
    status_e     err;
    logic        trunc;
  } state_t;

  state_t      st_q, st_d;
  out_t        out_q, res;
  logic        out_valid_q;
  logic        take;
  logic        fin, ad, ad_ext;
  logic [16:0] fin_pend, fin_len, ad_pend, rem_dec;
  logic [15:0] acc_new;
  logic [17:0] sum;
  status_e     stat;

  assign take        = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    st_d     = st_q;
    res      = '0;
    fin      = 1'b0;
    fin_pend = '0;
    fin_len  = '0;
    ad       = 1'b0;
    ad_pend  = '0;
    ad_ext   = 1'b0;
    sum      = '0;
    stat     = ST_OK;
    acc_new  = {st_q.acc[7:0], dec_i.data};
    rem_dec  = (st_q.rem != '0) ? st_q.rem - 17'd1 : '0;
    res.byte_kind = KIND_IGNORED;
    res.data_byte = dec_i.data;

    unique case (st_q.phase)
      PH_HEADER: begin
        res.byte_kind = KIND_HEADER;
        unique case (st_q.pos)
          2'd0: begin
            st_d       = '0;
            st_d.trunc = dec_i.trunc;
            st_d.pos   = 2'd1;
            if (!dec_i.ver_ok) begin
              st_d.err   = ST_VERSION;
              st_d.phase = PH_IGNORE;
            end else begin
              st_d.mtype = dec_i.data[5:4];
              st_d.tkl   = dec_i.data[3:0];
            end
          end
          2'd1: begin
            st_d.code = dec_i.data;
            st_d.pos  = 2'd2;
          end
          2'd2: begin
            st_d.id[15:8] = dec_i.data;
            st_d.pos      = 2'd3;
          end
          default: begin
            st_d.id[7:0] = dec_i.data;
            st_d.pos     = 2'd0;
            if (st_q.tkl != '0) begin
              st_d.rem   = 17'(st_q.tkl);
              st_d.phase = PH_TOKEN;
            end else begin
              st_d.phase = st_q.trunc ? PH_IGNORE : PH_OPTS;
            end
          end
        endcase
      end
      PH_TOKEN: begin
        res.byte_kind = KIND_TOKEN;
        st_d.rem = rem_dec;
        if (rem_dec == '0) begin
          st_d.phase = st_q.trunc ? PH_IGNORE : PH_OPTS;
        end
      end
      PH_OPTS: begin
        if (dec_i.marker) begin
          res.byte_kind = KIND_MARKER;
          st_d.phase    = PH_PAYLOAD;
        end else begin
          res.byte_kind = KIND_OPTHEAD;
          st_d.dn = dec_i.hi;
          st_d.ln = dec_i.lo;
          if (dec_i.nib15) begin
            st_d.err   = ST_NIBBLE15;
            st_d.phase = PH_IGNORE;
          end else if (dec_i.hi >= 4'd13) begin
            st_d.acc   = '0;
            st_d.rem   = 17'(dec_i.hi) - 17'd12;
            st_d.phase = PH_DEXT;
          end else begin
            st_d.pend = 17'(dec_i.hi);
            ad        = 1'b1;
            ad_pend   = 17'(dec_i.hi);
          end
        end
      end
      PH_DEXT: begin
        res.byte_kind = KIND_OPTEXT;
        st_d.acc = acc_new;
        st_d.rem = rem_dec;
        if (rem_dec == '0) begin
          ad_pend   = 17'(acc_new) + ((st_q.dn == 4'd13) ? 17'd13 : 17'd269);
          st_d.pend = ad_pend;
          ad        = 1'b1;
          ad_ext    = 1'b1;
        end
      end
      PH_LEXT: begin
        res.byte_kind = KIND_OPTEXT;
        st_d.acc = acc_new;
        st_d.rem = rem_dec;
        if (rem_dec == '0) begin
          fin      = 1'b1;
          fin_pend = st_q.pend;
          fin_len  = 17'(acc_new) + ((st_q.ln == 4'd13) ? 17'd13 : 17'd269);
        end
      end
      PH_VALUE: begin
        res.byte_kind = KIND_OPTVAL;
        st_d.rem = rem_dec;
        if (rem_dec == '0) begin
          st_d.phase = PH_OPTS;
        end
      end
      PH_PAYLOAD: begin
        res.byte_kind = KIND_PAYLOAD;
        if (st_q.pc < PayloadCap) begin
          st_d.pc = st_q.pc + 10'd1;
        end
      end
      default: begin
        res.byte_kind = KIND_IGNORED;
      end
    endcase

    if (ad) begin
      if ((ad_ext ? st_q.ln : dec_i.lo) >= 4'd13) begin
        st_d.acc   = '0;
        st_d.rem   = 17'(ad_ext ? st_q.ln : dec_i.lo) - 17'd12;
        st_d.phase = PH_LEXT;
      end else begin
        fin      = 1'b1;
        fin_pend = ad_pend;
        fin_len  = 17'(ad_ext ? st_q.ln : dec_i.lo);
      end
    end

    if (fin) begin
      sum = 18'(st_q.run) + 18'(fin_pend);
      if (sum[17:16] != 2'd0) begin
        st_d.err   = ST_OVERFLOW;
        st_d.phase = PH_IGNORE;
      end else begin
        st_d.run          = sum[15:0];
        res.option_start  = 1'b1;
        res.option_number = sum[15:0];
        res.option_length = fin_len;
        if (fin_len != '0) begin
          st_d.rem   = fin_len;
          st_d.phase = PH_VALUE;
        end else begin
          st_d.phase = PH_OPTS;
        end
      end
    end

    if (dec_i.last) begin
      stat = st_d.err;
      if (stat == ST_OK && (st_d.phase == PH_HEADER || st_d.phase == PH_TOKEN ||
          st_d.phase == PH_DEXT || st_d.phase == PH_LEXT || st_d.phase == PH_VALUE)) begin
        stat = ST_EARLY;
      end
      res.status         = stat;
      res.done_res       = 1'b1;
      res.payload_length = (stat == ST_OK && st_d.phase == PH_PAYLOAD) ? st_d.pc : '0;
      res.message_type   = st_d.mtype;
      res.message_code   = st_d.code;
      res.message_id     = st_d.id;
      res.token_length   = st_d.tkl;
      st_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        st_q <= st_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

endmodule

/* rtl/coap_message_byte_parser.sv */
`timescale 1ns / 1ps
// CoAP datagram byte parser. Each accepted input beat carries one datagram byte
// and yields exactly one result beat classifying it; the beat with last_byte set
// also reports status, header fields and payload length. Sustained rate is one
// byte per clock unless the output stalls, set by the back-end state update; a
// result waits in the queue, then in the output register. A two-entry queue
// between decoder and parser absorbs output stalls. The version register resets
// to 1; the user writes it through cfg_we_i while the block is idle (unenforced).
module coap_message_byte_parser import coapp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  dec_t dec, q_data;
  logic q_full, q_valid, q_pop;

  coapp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .dec_o       (dec)
  );

  assign in_ready_o = !q_full;

  coapp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (dec),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  coapp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .dec_i       (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/coapp_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module coapp_checker import coapp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input in_t        in_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_t       out_data_o,
  input logic       cfg_we_i,
  input logic [1:0] cfg_wdata_i
);

  `CHK_ASSERT_DFLT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `CHK_ASSERT_DFLT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o))
  `CHK_ASSERT_DFLT(a_start_kind, out_valid_o && out_data_o.option_start |-> (out_data_o.byte_kind == KIND_OPTHEAD || out_data_o.byte_kind == KIND_OPTEXT))
  `CHK_ASSERT_DFLT(a_idle_fields, out_valid_o && !out_data_o.done_res |-> (out_data_o.status == ST_OK && out_data_o.payload_length == '0 && out_data_o.message_id == '0))
  `CHK_ASSERT_DFLT(a_plen_ok, out_valid_o && out_data_o.payload_length != '0 |-> out_data_o.status == ST_OK)

endmodule

bind coap_message_byte_parser coapp_checker u_coapp_checker (.*);

/* bench/coap_parse_checker.sv */
`timescale 1ns / 1ps
module coap_parse_checker import coapp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_t       out_data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         done_count_o
);

  out_t       result_q[$];
  logic [1:0] version;
  phase_e     phase;
  logic [1:0] hpos;
  logic [16:0] remaining;
  logic [15:0] opt_num;
  logic [3:0] dnib, lnib;
  logic [15:0] ext_acc;
  logic [16:0] pend_delta;
  logic [9:0] pay_cnt;
  logic [1:0] f_type;
  logic [3:0] f_tkl;
  logic [7:0] f_code;
  logic [15:0] f_id;
  logic [2:0] err;
  logic       trunc;

  assign pending_o = result_q.size();

  task automatic clear_frame();
    phase = PH_HEADER; hpos = 0; remaining = 0; opt_num = 0; dnib = 0; lnib = 0;
    ext_acc = 0; pend_delta = 0; pay_cnt = 0; f_type = 0; f_tkl = 0; f_code = 0;
    f_id = 0; err = ST_OK; trunc = 0;
  endtask

  task automatic close_option(input logic [16:0] len, inout out_t r);
    logic [17:0] sum;
    sum = {2'b00, opt_num} + {1'b0, pend_delta};
    if (sum > 18'h0ffff) begin
      err = ST_OVERFLOW;
      phase = PH_IGNORE;
    end else begin
      opt_num = sum[15:0];
      r.option_start = 1;
      r.option_number = sum[15:0];
      r.option_length = len;
      if (len > 0) begin
        remaining = len;
        phase = PH_VALUE;
      end else begin
        phase = PH_OPTS;
      end
    end
  endtask

  task automatic after_delta(inout out_t r);
    if (lnib >= 13) begin
      ext_acc = 0;
      remaining = lnib - 12;
      phase = PH_LEXT;
    end else begin
      close_option({13'd0, lnib}, r);
    end
  endtask

  task automatic parse_byte(input in_t it);
    out_t r;
    logic [7:0] b;
    r = '0;
    b = it.rx_byte;
    r.data_byte = b;
    r.byte_kind = KIND_IGNORED;
    case (phase)
      PH_HEADER: begin
        r.byte_kind = KIND_HEADER;
        if (hpos == 0) begin
          clear_frame();
          trunc = it.truncated_frame;
          if (b[7:6] != version) begin
            err = ST_VERSION;
            phase = PH_IGNORE;
          end else begin
            f_type = b[5:4];
            f_tkl = b[3:0];
          end
          hpos = 1;
        end else if (hpos == 1) begin
          f_code = b;
          hpos = 2;
        end else if (hpos == 2) begin
          f_id[15:8] = b;
          hpos = 3;
        end else begin
          f_id[7:0] = b;
          hpos = 0;
          if (f_tkl > 0) begin
            remaining = f_tkl;
            phase = PH_TOKEN;
          end else begin
            phase = trunc ? PH_IGNORE : PH_OPTS;
          end
        end
      end
      PH_TOKEN: begin
        r.byte_kind = KIND_TOKEN;
        if (remaining > 0) remaining--;
        if (remaining == 0) phase = trunc ? PH_IGNORE : PH_OPTS;
      end
      PH_OPTS: begin
        if (b == 8'hff) begin
          r.byte_kind = KIND_MARKER;
          phase = PH_PAYLOAD;
        end else begin
          r.byte_kind = KIND_OPTHEAD;
          dnib = b[7:4];
          lnib = b[3:0];
          if (dnib == 15 || lnib == 15) begin
            err = ST_NIBBLE15;
            phase = PH_IGNORE;
          end else if (dnib >= 13) begin
            ext_acc = 0;
            remaining = dnib - 12;
            phase = PH_DEXT;
          end else begin
            pend_delta = dnib;
            after_delta(r);
          end
        end
      end
      PH_DEXT: begin
        r.byte_kind = KIND_OPTEXT;
        ext_acc = {ext_acc[7:0], b};
        if (remaining > 0) remaining--;
        if (remaining == 0) begin
          pend_delta = ext_acc + (dnib == 13 ? 17'd13 : 17'd269);
          after_delta(r);
        end
      end
      PH_LEXT: begin
        r.byte_kind = KIND_OPTEXT;
        ext_acc = {ext_acc[7:0], b};
        if (remaining > 0) remaining--;
        if (remaining == 0) close_option(ext_acc + (lnib == 13 ? 17'd13 : 17'd269), r);
      end
      PH_VALUE: begin
        r.byte_kind = KIND_OPTVAL;
        if (remaining > 0) remaining--;
        if (remaining == 0) phase = PH_OPTS;
      end
      PH_PAYLOAD: begin
        r.byte_kind = KIND_PAYLOAD;
        if (pay_cnt < PayloadCap) pay_cnt++;
      end
      default: r.byte_kind = KIND_IGNORED;
    endcase
    if (it.last_byte) begin
      r.done_res = 1;
      r.status = err;
      if (err == ST_OK && phase inside {PH_HEADER, PH_TOKEN, PH_DEXT, PH_LEXT, PH_VALUE})
        r.status = ST_EARLY;
      if (r.status == ST_OK && phase == PH_PAYLOAD) r.payload_length = pay_cnt;
      r.message_type = f_type;
      r.message_code = f_code;
      r.message_id = f_id;
      r.token_length = f_tkl;
      clear_frame();
    end
    result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e, a;
    if (!rst_ni) begin
      version = 2'd1;
      clear_frame();
      result_q.delete();
      fail_count_o <= 0;
      done_count_o <= 0;
    end else begin
      if (cfg_we_i) version = cfg_wdata_i;
      if (in_valid_i && in_ready_i) parse_byte(in_data_i);
      if (out_valid_i && out_ready_i) begin
        a = out_data_i;
        if (a.done_res) done_count_o <= done_count_o + 1;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = result_q.pop_front();
          if (e != a) begin
            fail_count_o <= fail_count_o + 1;
            if (e.byte_kind != a.byte_kind)
              $error("byte_kind exp %0d got %0d", e.byte_kind, a.byte_kind);
            if (e.data_byte != a.data_byte)
              $error("data_byte exp %0h got %0h", e.data_byte, a.data_byte);
            if (e.option_start != a.option_start)
              $error("option_start exp %0d got %0d", e.option_start, a.option_start);
            if (e.option_number != a.option_number)
              $error("option_number exp %0d got %0d", e.option_number, a.option_number);
            if (e.option_length != a.option_length)
              $error("option_length exp %0d got %0d", e.option_length, a.option_length);
            if (e.message_type != a.message_type)
              $error("message_type exp %0d got %0d", e.message_type, a.message_type);
            if (e.message_code != a.message_code)
              $error("message_code exp %0h got %0h", e.message_code, a.message_code);
            if (e.message_id != a.message_id)
              $error("message_id exp %0h got %0h", e.message_id, a.message_id);
            if (e.token_length != a.token_length)
              $error("token_length exp %0d got %0d", e.token_length, a.token_length);
            if (e.payload_length != a.payload_length)
              $error("payload_length exp %0d got %0d", e.payload_length, a.payload_length);
            if (e.done_res != a.done_res)
              $error("done_res exp %0d got %0d", e.done_res, a.done_res);
            if (e.status != a.status)
              $error("status exp %0d got %0d", e.status, a.status);
          end
        end
      end
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import coapp_pkg::*;

  localparam int CycleLimit = 400000;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid = 0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 0;
  out_t       out_data;
  logic       cfg_we = 0;
  logic [1:0] cfg_wdata = 0;
  int         fail_count, pending, done_count;
  int         cycles = 0;
  int         beats_sent = 0;
  bit         long_hold = 0;
  logic [1:0] cur_version = 2'd1;
  logic [7:0] frame_q[$];
  bit         trunc_q[$];

  always #6 clk_i = ~clk_i;

  coap_message_byte_parser u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  coap_parse_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .done_count_o(done_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (60) @(posedge clk_i);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1;
      @(posedge clk_i);
      while (!(out_valid && out_ready)) @(posedge clk_i);
    end
  end

  task automatic send_frame(input int max_gap);
    int gap, n;
    in_t item;
    n = frame_q.size();
    for (int i = 0; i < n; i++) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk_i);
      end
      item.rx_byte = frame_q[i];
      item.last_byte = (i == n - 1);
      item.truncated_frame = (i == 0) ? trunc_q[0] : 1'($urandom_range(0, 1));
      in_valid <= 1;
      in_data <= item;
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
      beats_sent++;
    end
    in_valid <= 0;
    frame_q.delete();
    trunc_q.delete();
    @(posedge clk_i);
  endtask

  task automatic build_frame(input bit good_version, input int plen);
    int tkl, nopt, len;
    logic [3:0] dn, ln;
    tkl = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    frame_q.push_back({good_version ? cur_version : 2'($urandom), 2'($urandom), 4'(tkl)});
    repeat (3) frame_q.push_back(8'($urandom));
    repeat (tkl) frame_q.push_back(8'($urandom));
    nopt = $urandom_range(0, 4);
    repeat (nopt) begin
      dn = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(13, 14)) : 4'($urandom_range(0, 12));
      ln = ($urandom_range(0, 5) == 0) ? 4'd13 : 4'($urandom_range(0, 6));
      if ($urandom_range(0, 30) == 0) ln = 4'd15;
      if ($urandom_range(0, 30) == 0) ln = 4'd14;
      frame_q.push_back({dn, ln});
      if (dn == 13) frame_q.push_back(8'($urandom));
      if (dn == 14) begin
        frame_q.push_back(($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom));
        frame_q.push_back(8'($urandom));
      end
      len = ln;
      if (ln == 13) begin
        frame_q.push_back(8'($urandom_range(0, 6)));
        len = 13 + frame_q[$];
      end
      if (ln == 14) begin
        frame_q.push_back(8'd0);
        frame_q.push_back(8'($urandom_range(0, 3)));
        len = 269 + frame_q[$];
      end
      if (ln != 15) repeat (len) frame_q.push_back(8'($urandom));
    end
    if (plen >= 0) begin
      frame_q.push_back(8'hff);
      repeat (plen) frame_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 8) == 0) begin
      len = $urandom_range(1, frame_q.size());
      while (frame_q.size() > len) void'(frame_q.pop_back());
    end
  endtask

  task automatic idle_then_config(input logic [1:0] v);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1;
    cfg_wdata <= v;
    cur_version = v;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  task automatic push_bytes(input logic [7:0] a[], input bit t);
    foreach (a[i]) frame_q.push_back(a[i]);
    trunc_q.push_back(t);
  endtask

  initial begin
    int plen;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    push_bytes('{8'h40, 8'h01, 8'h12, 8'h34}, 0); send_frame(0);
    push_bytes('{8'h52, 8'h45, 8'hff, 8'hff, 8'haa, 8'hbb, 8'hff, 8'h01}, 0); send_frame(2);
    push_bytes('{8'hc0, 8'h01, 8'h02}, 0); send_frame(0);
    push_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'hf1, 8'h00}, 0); send_frame(0);
    push_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'h1f}, 0); send_frame(0);
    push_bytes('{8'h41, 8'h01, 8'h00, 8'h00, 8'h77, 8'he0, 8'hff, 8'hff,
                 8'he0, 8'hff, 8'hf0}, 0); send_frame(0);
    push_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'hd1, 8'h05, 8'h00, 8'hff}, 0); send_frame(0);
    push_bytes('{8'h42, 8'h01, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'hff}, 1); send_frame(0);
    push_bytes('{8'h4f, 8'h01, 8'h00}, 0); send_frame(0);
    idle_then_config(2'd0);
    idle_then_config(2'd3);
    idle_then_config(2'd1);
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) idle_then_config(ph == 1 ? 2'd3 : ph == 2 ? 2'd0 : 2'd2);
      long_hold = 1;
      while (beats_sent < 150 + ph * 500) begin
        plen = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 10);
        if ($urandom_range(0, 40) == 0) plen = $urandom_range(900, 1030);
        if (plen > 500 && $urandom_range(0, 1)) plen = -1;
        build_frame($urandom_range(0, 9) != 0, plen);
        trunc_q.push_back($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 10) == 0) begin
          frame_q.delete();
          repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
        end
        if ($urandom_range(0, 30) == 0) long_hold = 1;
        if ($urandom_range(0, 20) == 0) while (pending != 0) @(posedge clk_i);
        send_frame($urandom_range(0, 1) ? 12 : 0);
      end
    end
    push_bytes('{8'h80, 8'h01, 8'h00, 8'h00, 8'hff, 8'h00}, 0); send_frame(0);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d byte beats over four version settings; %0d datagrams completed.",
             beats_sent, done_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
